>>> src/scaled_matrix_vector_multiply_top_defines.svh
// assertion macros shared by the scaled matrix-vector multiply rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef SCALED_MATRIX_VECTOR_MULTIPLY_TOP_DEFINES_SVH
`define SCALED_MATRIX_VECTOR_MULTIPLY_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SMVM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SMVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/smvm_pkg.sv
// package for the scaled matrix-vector multiply: sizes, codes, shared types
// no dependencies
package smvm_pkg;

  // sizes
  localparam int MAX_INNER   = 256;
  localparam int MAX_COLS    = 64;
  localparam int FRAC_BITS   = 12;
  localparam int DATA_W      = 16;
  localparam int ACC_W       = 48;
  localparam int OUT_W       = 32;
  localparam int STORE_DEPTH = MAX_INNER * MAX_COLS;
  localparam int ROW_AW      = $clog2(MAX_INNER);
  localparam int W_AW        = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int INNER_W     = 9;
  localparam int COLS_W      = 7;
  localparam int SIZE_W      = W_AW + 1;

  // register indexes
  localparam logic [1:0] REG_INNER_LEN = 2'd0;
  localparam logic [1:0] REG_OUT_COLS  = 2'd1;
  localparam logic [1:0] REG_SCALE     = 2'd2;

  // operation codes
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_INPUT  = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_SCALE = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // controls from the sequencer to the mac unit
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

>>> src/smvm_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module smvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/smvm_mac.sv
// shared multiply-accumulate unit: registered product, 48-bit accumulator
// depends on smvm_pkg
module smvm_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  smvm_pkg::mac_ctrl_t           ctrl,
  input  logic [smvm_pkg::DATA_W-1:0]   a,
  input  logic [smvm_pkg::DATA_W-1:0]   b,
  output logic                          busy,
  output logic signed [smvm_pkg::ACC_W-1:0] acc
);
  import smvm_pkg::*;

  logic signed [2*DATA_W-1:0] prod;
  logic                       prod_v;

  // product stage
  always_ff @(posedge clk) begin
    prod <= $signed(a) * $signed(b);
    if (rst || ctrl.clr) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctrl.en;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = prod_v;

endmodule

>>> src/smvm_finish.sv
// result stage: acc times scale over two half products, round, saturate
// depends on smvm_pkg
module smvm_finish (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [smvm_pkg::ACC_W-1:0] acc,
  input  logic signed [smvm_pkg::DATA_W-1:0] scale,
  output logic                              done,
  output logic signed [smvm_pkg::OUT_W-1:0] result
);
  import smvm_pkg::*;

  localparam int HALF_W = ACC_W / 2;
  localparam int MUL_W  = HALF_W + 1 + DATA_W;
  localparam int P_W    = ACC_W + DATA_W;
  localparam int SH     = 2 * FRAC_BITS;
  localparam int R_W    = P_W - SH;
  localparam logic signed [P_W-1:0] HALF =
    (SH > 0) ? (P_W'(1) <<< (SH - 1)) : P_W'(0);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_LO   = 5'b00010,
    F_HI   = 5'b00100,
    F_SUM  = 5'b01000,
    F_SAT  = 5'b10000
  } fin_phase_t;

  fin_phase_t               phase;
  fin_phase_t               phase_next;
  logic signed [HALF_W:0]   mul_a;
  logic signed [MUL_W-1:0]  mul_p;
  logic signed [MUL_W-1:0]  plo;
  logic signed [MUL_W-1:0]  phi;
  logic signed [P_W-1:0]    psum;
  logic signed [P_W-1:0]    rounded;
  logic signed [R_W-1:0]    shifted;
  logic                     fits;

  // phase sequencer
  always_comb begin
    phase_next = phase;
    unique case (phase)
      F_IDLE: if (start) phase_next = F_LO;
      F_LO:   phase_next = F_HI;
      F_HI:   phase_next = F_SUM;
      F_SUM:  phase_next = F_SAT;
      F_SAT:  phase_next = F_IDLE;
      default: phase_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= F_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == F_SAT);
    end
  end

  // one multiplier: low half unsigned, then high half signed
  assign mul_a = (phase == F_LO) ? $signed({1'b0, acc[HALF_W-1:0]})
                                 : $signed({acc[ACC_W-1], acc[ACC_W-1:HALF_W]});
  assign mul_p = MUL_W'(mul_a * scale);

  // round half up, then floor shift and saturate
  assign rounded = psum + HALF;
  assign shifted = rounded[P_W-1:SH];
  assign fits    = (shifted[R_W-1:OUT_W-1] == '0) || (shifted[R_W-1:OUT_W-1] == '1);

  always_ff @(posedge clk) begin
    if (phase == F_LO) begin
      plo <= mul_p;
    end
    if (phase == F_HI) begin
      phi <= mul_p;
    end
    if (phase == F_SUM) begin
      psum <= (P_W'(phi) <<< HALF_W) + P_W'(plo);
    end
    if (phase == F_SAT) begin
      if (fits) begin
        result <= shifted[OUT_W-1:0];
      end else if (shifted[R_W-1]) begin
        result <= {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        result <= {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
  end

endmodule

>>> src/scaled_matrix_vector_multiply_top.sv
// scaled matrix-vector multiply top: config, sequencer, memories, mac, result stage
// depends on smvm_pkg, smvm_ram, smvm_mac, smvm_finish and the defines header
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | in_valid / in_ready  | op, value
//  output   | out_valid / out_ready| out_value, col_index, row_last
//  config   | cfg_we               | cfg_index, cfg_data
//
// a weight word or an input word that does not finish a row is taken while in_ready stays high
// a word that finishes a row starts the column walk: one
// shared multiply-accumulate walks every weight of each column, then the result
// stage scales it; in_ready is low for that whole time
// a stalled output holds the sequencer before the next column starts
// synchronous reset clears the pointers and counters; memory contents are kept
`include "scaled_matrix_vector_multiply_top_defines.svh"

module scaled_matrix_vector_multiply_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic signed [smvm_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [smvm_pkg::OUT_W-1:0]  out_value,
  output logic [smvm_pkg::COL_W-1:0]         col_index,
  output logic                               row_last,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [smvm_pkg::DATA_W-1:0]        cfg_data
);
  import smvm_pkg::*;

  // configuration registers
  logic [INNER_W-1:0]       inner_len;
  logic [COLS_W-1:0]        out_cols;
  logic signed [DATA_W-1:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_len <= INNER_W'(MAX_INNER);
      out_cols  <= COLS_W'(MAX_COLS);
      scale     <= DATA_W'(1 << FRAC_BITS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INNER_LEN: inner_len <= cfg_data[INNER_W-1:0];
        REG_OUT_COLS:  out_cols  <= cfg_data[COLS_W-1:0];
        REG_SCALE:     scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [INNER_W-1:0] n_eff;
  logic [COLS_W-1:0]  c_eff;
  logic [SIZE_W-1:0]  size;

  assign n_eff = (inner_len == '0) ? INNER_W'(1)
               : (inner_len > INNER_W'(MAX_INNER)) ? INNER_W'(MAX_INNER) : inner_len;
  assign c_eff = (out_cols == '0) ? COLS_W'(1)
               : (out_cols > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : out_cols;
  assign size  = SIZE_W'(n_eff * c_eff);

  // sequencer and pointer registers
  state_t             state;
  state_t             state_next;
  logic [W_AW-1:0]    wptr;
  logic [W_AW-1:0]    wa_cur;
  logic [W_AW:0]      wa_inc;
  logic [ROW_AW-1:0]  count;
  logic [INNER_W-1:0] count_inc;
  logic [ROW_AW-1:0]  k;
  logic [COL_W-1:0]   j;
  logic [W_AW-1:0]    raddr_w;
  logic               rd_v1;
  logic               accept;
  logic               row_done;
  logic               k_last;
  logic               drained;
  logic               slot_free;
  logic               load;
  logic               col_last;
  mac_ctrl_t          mac_ctrl;
  logic               mac_busy;
  logic signed [ACC_W-1:0] acc;
  logic               fin_done;
  logic signed [OUT_W-1:0] fin_result;
  logic [DATA_W-1:0]  row_rdata;
  logic [DATA_W-1:0]  w_rdata;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign count_inc = INNER_W'(count) + INNER_W'(1);
  assign row_done  = accept && (op == OP_INPUT) && (count_inc >= n_eff);
  assign k_last    = ({1'b0, k} == n_eff - INNER_W'(1));
  assign drained   = !rd_v1 && !mac_busy;
  assign slot_free = !out_valid || out_ready;
  assign load      = (state == S_OUT) && slot_free;
  assign col_last  = (COLS_W'(j) == c_eff - COLS_W'(1));

  // weight write address with wrap
  assign wa_cur = (SIZE_W'(wptr) >= size) ? '0 : wptr;
  assign wa_inc = (W_AW + 1)'(wa_cur) + (W_AW + 1)'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (row_done) state_next = S_RUN;
      S_RUN:   if (k_last) state_next = S_DRAIN;
      S_DRAIN: if (drained) state_next = S_SCALE;
      S_SCALE: if (fin_done) state_next = S_OUT;
      S_OUT: begin
        if (load) begin
          state_next = col_last ? S_IDLE : S_RUN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // mac clears as a column starts, takes data in the cycle after a read
  assign mac_ctrl.clr = row_done || (load && !col_last);
  assign mac_ctrl.en  = rd_v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr  <= '0;
      count <= '0;
      rd_v1 <= 1'b0;
      k     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      rd_v1 <= (state == S_RUN);
      // weight pointer
      if (accept && (op == OP_WEIGHT)) begin
        wptr <= ((W_AW + 1)'(wa_inc) >= (W_AW + 1)'(size)) ? '0 : wa_inc[W_AW-1:0];
      end
      // input element count
      if (accept && (op == OP_INPUT)) begin
        count <= row_done ? '0 : count_inc[ROW_AW-1:0];
      end
      // column walk
      if (row_done) begin
        k <= '0;
        j <= '0;
      end else if (state == S_RUN) begin
        k <= k + ROW_AW'(1);
      end else if (load && !col_last) begin
        k <= '0;
        j <= j + COL_W'(1);
      end
    end
  end

  // weight read address steps by the clamped column count along the column
  always_ff @(posedge clk) begin
    if (row_done) begin
      raddr_w <= '0;
    end else if (state == S_RUN) begin
      raddr_w <= raddr_w + W_AW'(c_eff);
    end else if (load && !col_last) begin
      raddr_w <= W_AW'(j) + W_AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= fin_result;
      col_index <= j;
      row_last  <= col_last;
    end
  end

  // memories
  smvm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (accept && (op == OP_WEIGHT)),
    .waddr (wa_cur),
    .wdata (value),
    .raddr (raddr_w),
    .rdata (w_rdata)
  );

  smvm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_INNER)) u_row_ram (
    .clk   (clk),
    .we    (accept && (op == OP_INPUT)),
    .waddr (count),
    .wdata (value),
    .raddr (k),
    .rdata (row_rdata)
  );

  // shared multiply-accumulate
  smvm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (row_rdata),
    .b    (w_rdata),
    .busy (mac_busy),
    .acc  (acc)
  );

  // scale, round and saturate
  smvm_finish u_finish (
    .clk    (clk),
    .rst    (rst),
    .start  ((state == S_DRAIN) && drained),
    .acc    (acc),
    .scale  (scale),
    .done   (fin_done),
    .result (fin_result)
  );

  // checks
  `SMVM_ASSERT_NOW(a_idle_no_reads, clk, rst, in_ready, !rd_v1 && !mac_busy, "reads in flight while idle")
  `SMVM_ASSERT_NEXT(a_last_to_idle, clk, rst, load && col_last, in_ready && out_valid && row_last, "row end did not return to idle")
  `SMVM_ASSERT_NOW(a_done_in_scale, clk, rst, fin_done, state == S_SCALE, "result stage done outside scale state")

endmodule
